### sv/sa_pkg.sv
// Package for the subsequence automaton unit: sizes, codes, item and
// handshake structs, and the letter decoding function. Depends on nothing.
package sa_pkg;

  localparam int unsigned MAX_LEN       = 255;
  localparam int unsigned ALPHABET_SIZE = 26;
  localparam int unsigned BASE_SYMBOL   = 97;

  // Width of positions, lengths and table entries, fixed by the item fields.
  localparam int unsigned PW  = 9;
  // Row index of the table and address of the source store.
  localparam int unsigned RW  = $clog2(MAX_LEN + 1);
  // Letter column of the table.
  localparam int unsigned LW  = $clog2(ALPHABET_SIZE);
  // Letter index including the code for a symbol outside the alphabet.
  localparam int unsigned LIW = $clog2(ALPHABET_SIZE + 1);
  localparam int unsigned TAW = RW + LW;

  localparam int unsigned SRC_DEPTH = 2 ** RW;
  localparam int unsigned TBL_DEPTH = 2 ** TAW;

  localparam logic [LIW-1:0] NO_LETTER   = LIW'(ALPHABET_SIZE);
  localparam logic [LW-1:0]  LAST_LETTER = LW'(ALPHABET_SIZE - 1);

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_MATCH = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_MATCH = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] symbol;
    logic [8:0] position;
    logic       last;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic       matched;
    logic [8:0] next_position;
    logic       overflow;
  } out_item_t;

  // Request from the control to the table builder.
  typedef struct packed {
    logic          start;
    logic [PW-1:0] len;
  } build_req_t;

  // Memory accesses and completion from the table builder.
  typedef struct packed {
    logic [RW-1:0]  src_raddr;
    logic           tbl_we;
    logic [TAW-1:0] tbl_waddr;
    logic [PW-1:0]  tbl_wdata;
    logic           done;
  } build_rsp_t;

  // Letter index of a raw byte, or NO_LETTER when it is outside the alphabet.
  function automatic logic [LIW-1:0] letter_of(logic [7:0] sym);
    logic [8:0] diff;
    logic       ok;
    diff = 9'(sym) - 9'(BASE_SYMBOL);
    ok   = (sym >= 8'(BASE_SYMBOL)) && (diff < 9'(ALPHABET_SIZE));
    return ok ? LIW'(diff) : NO_LETTER;
  endfunction

endpackage

### sv/subsequence_automaton_unit.sv
// Subsequence automaton unit; depends on sa_pkg, sa_ram and sa_build. The last load transfer
// starts the table build, which makes one table write per cycle while it writes, and its
// result is registered in the cycle after the last write. Match and query transfers wait
// on the registered read of the table RAM in a lookup state. The input stalls during a build,
// a lookup, or while a result is held.
// Reset clears all control state and leaves an empty source's table in effect at once.
module subsequence_automaton_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sa_pkg::in_item_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sa_pkg::out_item_t out_data_o
);
  import sa_pkg::*;

  // One-hot control states: waiting for a transfer, finishing a table lookup,
  // and waiting for the table builder.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_LOOK  = 3'b010,
    ST_BUILD = 3'b100
  } state_e;

  state_e         state_q, state_d;
  logic [PW-1:0]  load_cnt_q, load_cnt_d;
  logic           ovf_q, ovf_d;
  logic           ovf_rep_q, ovf_rep_d;
  logic [PW-1:0]  length_q, length_d;
  logic [PW-1:0]  build_len_q, build_len_d;
  logic [PW-1:0]  cursor_q, cursor_d;
  logic           failed_q, failed_d;
  // Fields of the match or query transfer whose lookup is in flight.
  logic           is_match_q, is_match_d;
  logic           letter_ok_q, letter_ok_d;
  logic [PW-1:0]  pos_q, pos_d;
  logic           last_q, last_d;
  logic           out_valid_q, out_valid_d;
  out_item_t      out_data_q, out_data_d;

  logic           accept;
  logic [LIW-1:0] in_letter;
  logic           load_full;
  logic           src_we;
  logic [RW-1:0]  tbl_row;
  logic [TAW-1:0] tbl_raddr;
  logic [PW-1:0]  tbl_rdata;
  logic [LIW-1:0] src_rdata;
  logic           res_valid;
  out_item_t      res_data;
  logic           step_ok;
  build_req_t     bld_req;
  build_rsp_t     bld_rsp;

  // The input side stalls while a lookup or a build is under way, and while
  // a finished result waits to be taken so that it is never overwritten.
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_letter  = letter_of(in_data_i.symbol);
  assign load_full  = (load_cnt_q >= PW'(MAX_LEN));
  assign src_we     = accept && (in_data_i.func == FUNC_LOAD) && !load_full;

  // A match reads the row of its cursor, a query the row it names. Rows at or
  // beyond the current length hold no entry of the current source; such reads are ignored.
  assign tbl_row   = (in_data_i.func == FUNC_MATCH) ? cursor_q[RW-1:0]
                                                    : in_data_i.position[RW-1:0];
  assign tbl_raddr = {tbl_row, in_letter[LW-1:0]};

  assign bld_req.start = accept && (in_data_i.func == FUNC_LOAD) && in_data_i.last;
  assign bld_req.len   = load_full ? load_cnt_q : load_cnt_q + PW'(1);

  // A step of a match can only advance from a row strictly below the length;
  // the last row sends every letter past the end.
  assign step_ok = !failed_q && letter_ok_q && (cursor_q < length_q);

  always_comb begin
    state_d     = state_q;
    load_cnt_d  = load_cnt_q;
    ovf_d       = ovf_q;
    ovf_rep_d   = ovf_rep_q;
    length_d    = length_q;
    build_len_d = build_len_q;
    cursor_d    = cursor_q;
    failed_d    = failed_q;
    is_match_d  = is_match_q;
    letter_ok_d = letter_ok_q;
    pos_d       = pos_q;
    last_d      = last_q;
    res_valid   = 1'b0;
    res_data    = '{kind: KIND_LOAD, matched: 1'b0, next_position: '0, overflow: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.func) inside
            FUNC_LOAD: begin
              if (load_full) begin
                ovf_d = 1'b1;
              end else begin
                load_cnt_d = load_cnt_q + PW'(1);
              end
              if (in_data_i.last) begin
                ovf_rep_d   = ovf_q || load_full;
                ovf_d       = 1'b0;
                load_cnt_d  = '0;
                build_len_d = bld_req.len;
                state_d     = ST_BUILD;
              end
            end
            FUNC_MATCH, FUNC_QUERY: begin
              is_match_d  = (in_data_i.func == FUNC_MATCH);
              letter_ok_d = (in_letter != NO_LETTER);
              pos_d       = in_data_i.position;
              last_d      = in_data_i.last;
              state_d     = ST_LOOK;
            end
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        state_d = ST_IDLE;
        if (is_match_q) begin
          if (step_ok && (tbl_rdata <= length_q)) begin
            cursor_d = tbl_rdata;
          end else begin
            failed_d = 1'b1;
          end
          if (last_q) begin
            res_valid        = 1'b1;
            res_data.kind    = KIND_MATCH;
            res_data.matched = step_ok && (tbl_rdata <= length_q);
            cursor_d         = '0;
            failed_d         = 1'b0;
          end
        end else begin
          res_valid     = 1'b1;
          res_data.kind = KIND_QUERY;
          if (letter_ok_q && (pos_q < length_q)) begin
            res_data.next_position = tbl_rdata;
          end else begin
            res_data.next_position = length_q + PW'(1);
          end
        end
      end
      ST_BUILD: begin
        if (bld_rsp.done) begin
          length_d          = build_len_q;
          res_valid         = 1'b1;
          res_data.kind     = KIND_LOAD;
          res_data.overflow = ovf_rep_q;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_data_d  = res_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      load_cnt_q  <= '0;
      ovf_q       <= 1'b0;
      ovf_rep_q   <= 1'b0;
      length_q    <= '0;
      build_len_q <= '0;
      cursor_q    <= '0;
      failed_q    <= 1'b0;
      is_match_q  <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      ovf_q       <= ovf_d;
      ovf_rep_q   <= ovf_rep_d;
      length_q    <= length_d;
      build_len_q <= build_len_d;
      cursor_q    <= cursor_d;
      failed_q    <= failed_d;
      is_match_q  <= is_match_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    letter_ok_q <= letter_ok_d;
    pos_q       <= pos_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Letters of the source being loaded; the builder reads them back.
  sa_ram #(
    .WIDTH(LIW),
    .DEPTH(SRC_DEPTH)
  ) u_src_ram (
    .clk_i  (clk_i),
    .we_i   (src_we),
    .waddr_i(load_cnt_q[RW-1:0]),
    .wdata_i(in_letter),
    .raddr_i(bld_rsp.src_raddr),
    .rdata_o(src_rdata)
  );

  // Next-occurrence table, one row per source position and one column per
  // letter.
  sa_ram #(
    .WIDTH(PW),
    .DEPTH(TBL_DEPTH)
  ) u_tbl_ram (
    .clk_i  (clk_i),
    .we_i   (bld_rsp.tbl_we),
    .waddr_i(bld_rsp.tbl_waddr),
    .wdata_i(bld_rsp.tbl_wdata),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  sa_build u_build (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (bld_req),
    .src_rdata_i(src_rdata),
    .rsp_o      (bld_rsp)
  );

`ifndef NO_ASSERTIONS
  // The builder finishes only while the control waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bld_rsp.done |-> (state_q == ST_BUILD))
    else $error("table build finished outside the build state");

  // The table is never rewritten while a lookup reads it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bld_rsp.tbl_we |-> (state_q == ST_BUILD))
    else $error("table write outside the build state");

  // A new result never replaces one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !(out_valid_q && out_stall_i))
    else $error("result produced while the output register is held");

  // A build is started only with a nonzero length within capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bld_req.start |-> (bld_req.len != '0) && (bld_req.len <= PW'(MAX_LEN)))
    else $error("table build started with a bad length");
`endif

endmodule

### sv/sa_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
module sa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/sa_build.sv
// Table builder: sweeps the loaded source backwards and, after reading each
// symbol, writes one table entry per cycle. Depends on sa_pkg.
module sa_build (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sa_pkg::build_req_t    req_i,
  input  logic [sa_pkg::LIW-1:0] src_rdata_i,
  output sa_pkg::build_rsp_t    rsp_o
);
  import sa_pkg::*;

  typedef enum logic [3:0] {
    BS_IDLE   = 4'b0001,
    BS_READ   = 4'b0010,
    BS_UPDATE = 4'b0100,
    BS_WRITE  = 4'b1000
  } bstate_e;

  bstate_e       state_q, state_d;
  logic [RW-1:0] row_q, row_d;
  logic [LW-1:0] let_q, let_d;
  // Next occurrence of each letter after the row being written.
  logic [PW-1:0] occ_q [ALPHABET_SIZE];
  logic          last_write;

  assign last_write = (state_q == BS_WRITE) && (let_q == LAST_LETTER);

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    let_d   = let_q;
    unique case (state_q)
      BS_IDLE: begin
        if (req_i.start) begin
          row_d   = RW'(req_i.len - PW'(1));
          state_d = BS_READ;
        end
      end
      BS_READ: begin
        state_d = BS_UPDATE;
      end
      BS_UPDATE: begin
        let_d   = '0;
        state_d = BS_WRITE;
      end
      BS_WRITE: begin
        let_d = let_q + LW'(1);
        if (last_write) begin
          if (row_q == '0) begin
            state_d = BS_IDLE;
          end else begin
            row_d   = row_q - RW'(1);
            state_d = BS_READ;
          end
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      row_q   <= '0;
      let_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      let_q   <= let_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BS_IDLE && req_i.start) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        occ_q[i] <= req_i.len + PW'(1);
      end
    end else if (state_q == BS_UPDATE && src_rdata_i != NO_LETTER) begin
      occ_q[src_rdata_i[LW-1:0]] <= PW'(row_q) + PW'(1);
    end
  end

  assign rsp_o.src_raddr = row_q;
  assign rsp_o.tbl_we    = (state_q == BS_WRITE);
  assign rsp_o.tbl_waddr = {row_q, let_q};
  assign rsp_o.tbl_wdata = occ_q[let_q];
  assign rsp_o.done      = last_write && (row_q == '0);

endmodule
